/* rtl/bpfa_pkg.sv */
// ============================================================================
// bpfa_pkg - bitmap page frame allocator package
// Shared types, codes and reset constants for the allocator block.
// ============================================================================
package bpfa_pkg;

    // Default geometry (block size must be a power of two)
    localparam int NUM_BLOCKS_DEF  = 4096;
    localparam int BLOCK_BYTES_DEF = 4096;

    // Configuration register widths and reset values
    localparam int AVAIL_W  = 13;
    localparam int KBLOCK_W = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [AVAIL_W-1:0]  AVAIL_RST  = 13'd4096;
    localparam logic [KBLOCK_W-1:0] KFIRST_RST = 12'd256;
    localparam logic [KBLOCK_W-1:0] KLAST_RST  = 12'd511;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AVAIL  = 2'd0,
        CFG_KFIRST = 2'd1,
        CFG_KLAST  = 2'd2
    } t_cfg_index;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_INIT        = 2'd0,
        OP_ALLOC_ANY   = 2'd1,
        OP_ALLOC_GIVEN = 2'd2,
        OP_FREE        = 2'd3
    } t_opcode;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_SPACE    = 3'd1,
        ST_UNALIGNED   = 3'd2,
        ST_RANGE       = 3'd3,
        ST_DOUBLE_FREE = 3'd4
    } t_status;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] block_address;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_address;
        t_status     status;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic sweep;
        logic sweep_clear;
        logic scan;
        logic check;
        logic load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last_word;
        logic scan_done;
    } t_dp_stat;

endpackage

/* rtl/bitmap_page_frame_allocator.sv */
// ============================================================================
// bitmap_page_frame_allocator - physical page frame allocator, top level
// One used bit per block, kept in a word-wide map RAM.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one request item: init map,
//   allocate any, allocate given, or free. Each item gives exactly one output
//   item (o_out_valid / i_out_ready) with a byte address and a status.
//   Configuration writes (i_cfg_valid, i_cfg_index, i_cfg_data) are always
//   ready; user must place them between requests, not enforced by the block.
//   Processing per item, from accept to output valid:
//     allocate given / free : the addressed map word is read and checked
//     allocate any          : map words are read in turn until a free bit,
//                             at most NUM_BLOCKS/32 words (128 at the defaults)
//     init                  : every map word is written with its pattern
//   The map RAM has one write port and one read port, one 32-bit word at a
//   time. One item is in progress at a time.
//   Reset: a clearing pass writes every map word to zero, with o_in_ready
//   low; configuration returns to 4096, 256, 511.
//   A stalled receiver holds the finished item in the output register; the
//   next request is still accepted and waits at completion for room.
// ============================================================================
module bitmap_page_frame_allocator #(
    parameter int NUM_BLOCKS  = bpfa_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = bpfa_pkg::BLOCK_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bpfa_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bpfa_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bpfa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Configuration registers never stall
    assign o_cfg_ready = 1'b1;

    bpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_in_item.opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    bpfa_dp #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_item  (o_out_item)
    );

endmodule

/* rtl/bpfa_ram.sv */
// ============================================================================
// bpfa_ram - generic single write, single read RAM
// One write port, one read port with registered read data.
// ============================================================================
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bpfa_ctrl.sv */
// ============================================================================
// bpfa_ctrl - allocator controller
// Sequences clear pass, init sweep, free-block scan and single-block checks,
// and owns the output item valid.
// ============================================================================
module bpfa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bpfa_pkg::t_opcode  i_opcode,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bpfa_pkg::t_dp_cmd  o_cmd,
    input  bpfa_pkg::t_dp_stat i_stat
);
    import bpfa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_CHECK,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    // Command decode
    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep       = 1'b1;
                o_cmd.sweep_clear = 1'b1;
            end
            S_INIT:  o_cmd.sweep = 1'b1;
            S_SCAN:  o_cmd.scan  = 1'b1;
            S_CHECK: o_cmd.check = 1'b1;
            S_DONE:  o_cmd.load  = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_stat.last_word) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_opcode)
                        OP_INIT:        n_state = S_INIT;
                        OP_ALLOC_ANY:   n_state = S_SCAN;
                        OP_ALLOC_GIVEN: n_state = S_CHECK;
                        OP_FREE:        n_state = S_CHECK;
                        default:        n_state = S_CHECK;
                    endcase
                end
            end
            S_INIT:  if (i_stat.last_word) n_state = S_DONE;
            S_SCAN:  if (i_stat.scan_done) n_state = S_DONE;
            S_CHECK: n_state = S_DONE;
            S_DONE:  if (o_cmd.load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still open after accepting an item");
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("output valid raised outside completion");
    a_init_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_opcode == OP_INIT) |=> r_state == S_INIT)
        else $error("init item did not start the sweep");
`endif

endmodule

/* rtl/bpfa_dp.sv */
// ============================================================================
// bpfa_dp - allocator datapath
// Used map RAM, word pointer, configuration registers, request decode,
// free-bit search and result registers.
// ============================================================================
module bpfa_dp #(
    parameter int NUM_BLOCKS  = bpfa_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = bpfa_pkg::BLOCK_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bpfa_pkg::t_dp_cmd                   i_cmd,
    output bpfa_pkg::t_dp_stat                  o_stat,
    input  bpfa_pkg::t_in_item                  i_in_item,
    input  logic                                i_cfg_valid,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpfa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output bpfa_pkg::t_out_item                 o_out_item
);
    import bpfa_pkg::*;

    localparam int WORDS     = (NUM_BLOCKS + 31) / 32;
    localparam int WADDR_W   = $clog2(WORDS);
    localparam int SHIFT     = $clog2(BLOCK_BYTES);
    localparam int LAST_BITS = NUM_BLOCKS - (WORDS - 1) * 32;
    localparam int CMP_W     = (WADDR_W + 5 > AVAIL_W) ? WADDR_W + 5 : AVAIL_W;
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
    // bits of the last word past the final block count as used in the scan
    localparam logic [31:0] TAIL_USED = ~((32'h1 << LAST_BITS) - 32'h1);
    localparam logic [31:0] OFS_MASK  = (32'h1 << SHIFT) - 32'h1;

    // Configuration registers
    logic [AVAIL_W-1:0]  r_avail;
    logic [KBLOCK_W-1:0] r_kfirst;
    logic [KBLOCK_W-1:0] r_klast;

    // Working registers
    logic [WADDR_W-1:0] r_word;
    logic [4:0]         r_bit;
    t_opcode            r_op;
    t_out_item          r_result;
    t_out_item          r_out;

    // RAM port signals
    logic               ram_we;
    logic [WADDR_W-1:0] ram_waddr;
    logic [31:0]        ram_wdata;
    logic [WADDR_W-1:0] ram_raddr;
    logic [31:0]        ram_rdata;

    // Request decode
    logic [31:0]        acc_index;
    logic               acc_unaligned;
    logic               acc_range;
    t_status            acc_status;
    logic [WADDR_W-1:0] acc_word;
    logic               acc_single;
    logic               last_word;

    // Scan and check
    logic [31:0] scan_word, scan_free, scan_onehot;
    logic        scan_found;
    logic [4:0]  scan_bit;
    logic [31:0] scan_addr;
    logic [31:0] bit_mask;
    logic        bit_set;
    logic [31:0] check_addr;
    logic [31:0] init_mask;

    assign last_word     = (r_word == LAST_WORD);
    assign acc_index     = i_in_item.block_address >> SHIFT;
    assign acc_unaligned = (i_in_item.block_address & OFS_MASK) != 32'h0;
    assign acc_range     = acc_index >= 32'(NUM_BLOCKS);
    assign acc_word      = acc_index[WADDR_W+4:5];
    assign acc_single    = (i_in_item.opcode == OP_ALLOC_GIVEN) ||
                           (i_in_item.opcode == OP_FREE);

    always_comb begin
        if (acc_unaligned) begin
            acc_status = ST_UNALIGNED;
        end else if (acc_range) begin
            acc_status = ST_RANGE;
        end else begin
            acc_status = ST_OK;
        end
    end

    // Lowest free bit of the word under scan
    always_comb begin
        scan_word   = ram_rdata | (last_word ? TAIL_USED : 32'h0);
        scan_free   = ~scan_word;
        scan_onehot = scan_free & (~scan_free + 32'h1);
        scan_found  = |scan_free;
        scan_bit    = 5'd0;
        for (int b = 0; b < 32; b++) begin
            scan_bit = scan_bit | (scan_onehot[b] ? 5'(b) : 5'd0);
        end
    end

    assign scan_addr  = 32'({r_word, scan_bit}) << SHIFT;
    assign bit_mask   = 32'h1 << r_bit;
    assign bit_set    = |(ram_rdata & bit_mask);
    assign check_addr = 32'({r_word, r_bit}) << SHIFT;

    // Init pattern for one map word: past available, block 0, kernel range
    always_comb begin
        logic [CMP_W-1:0] blk;
        init_mask = 32'h0;
        for (int b = 0; b < 32; b++) begin
            blk = CMP_W'({r_word, 5'(b)});
            init_mask[b] = (blk >= CMP_W'(r_avail)) || (blk == '0) ||
                           ((blk >= CMP_W'(r_kfirst)) && (blk <= CMP_W'(r_klast)));
        end
    end

    // RAM write selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_word;
        ram_wdata = 32'h0;
        priority if (i_cmd.sweep) begin
            ram_we    = 1'b1;
            ram_wdata = i_cmd.sweep_clear ? 32'h0 : init_mask;
        end else if (i_cmd.scan && scan_found) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | scan_onehot;
        end else if (i_cmd.check && r_result.status == ST_OK) begin
            if (r_op == OP_ALLOC_GIVEN && !bit_set) begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | bit_mask;
            end else if (r_op == OP_FREE && bit_set) begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~bit_mask;
            end
        end else begin
            ram_we = 1'b0;
        end
    end

    // RAM read address
    always_comb begin
        priority if (i_cmd.accept) begin
            ram_raddr = acc_single ? acc_word : '0;
        end else if (i_cmd.scan) begin
            ram_raddr = last_word ? r_word : r_word + 1'b1;
        end else begin
            ram_raddr = r_word;
        end
    end

    bpfa_ram #(
        .WIDTH (32),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Working registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word   <= '0;
            r_bit    <= '0;
            r_op     <= OP_INIT;
            r_result <= '0;
            r_avail  <= AVAIL_RST;
            r_kfirst <= KFIRST_RST;
            r_klast  <= KLAST_RST;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_AVAIL) begin
                    r_avail <= i_cfg_data[AVAIL_W-1:0];
                end else if (i_cfg_index == CFG_KFIRST) begin
                    r_kfirst <= i_cfg_data[KBLOCK_W-1:0];
                end else if (i_cfg_index == CFG_KLAST) begin
                    r_klast <= i_cfg_data[KBLOCK_W-1:0];
                end
            end

            if (i_cmd.accept) begin
                r_op   <= i_in_item.opcode;
                r_bit  <= acc_index[4:0];
                r_word <= acc_single ? acc_word : '0;
                r_result.result_address <= 32'h0;
                r_result.status         <= acc_single ? acc_status : ST_OK;
            end

            if (i_cmd.sweep) begin
                r_word <= last_word ? '0 : r_word + 1'b1;
            end

            if (i_cmd.scan) begin
                if (scan_found) begin
                    r_result.result_address <= scan_addr;
                    r_result.status         <= ST_OK;
                end else if (last_word) begin
                    r_result.result_address <= 32'h0;
                    r_result.status         <= ST_NO_SPACE;
                end else begin
                    r_word <= r_word + 1'b1;
                end
            end

            if (i_cmd.check && r_result.status == ST_OK) begin
                if (r_op == OP_ALLOC_GIVEN) begin
                    if (bit_set) begin
                        r_result.status <= ST_NO_SPACE;
                    end else begin
                        r_result.result_address <= check_addr;
                    end
                end else if (!bit_set) begin
                    r_result.status <= ST_DOUBLE_FREE;
                end
            end
        end
    end

    // Output item register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= r_result;
        end
    end

    assign o_stat.last_word = last_word;
    assign o_stat.scan_done = scan_found || last_word;
    assign o_out_item       = r_out;

`ifndef SYNTHESIS
    a_waddr_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ram_waddr <= LAST_WORD)
        else $error("map write beyond last word");
    a_scan_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && ram_we) |-> $countones(ram_wdata ^ ram_rdata) == 1)
        else $error("scan claim changed other than one bit");
    a_addr_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_result.result_address != 32'h0) |-> r_result.status == ST_OK)
        else $error("address returned with a failure status");
`endif

endmodule

/* tb/bitmap_page_frame_allocator_tb.sv */
// ============================================================================
// bitmap_page_frame_allocator_tb - self-checking bench for the frame allocator
// Drives request items through the valid/ready input channel and checks every
// output item against a bench-side copy of the used map. Directed requests
// cover use before init, the address error codes, kernel and memory limits and
// a full map. Randomised phases follow, each with its own register settings,
// most with random idling on both channels; two long receiver hold-offs run.
// ============================================================================
module bitmap_page_frame_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfa_pkg::*;

    localparam int NUM_BLOCKS  = NUM_BLOCKS_DEF;
    localparam int BLOCK_BYTES = BLOCK_BYTES_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #10 i_clk = ~i_clk;

    // Block ports
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    bitmap_page_frame_allocator #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Bench-side allocator state
    bit                  frame_used [NUM_BLOCKS];
    logic [AVAIL_W-1:0]  avail_blocks = AVAIL_RST;
    logic [KBLOCK_W-1:0] kern_first   = KFIRST_RST;
    logic [KBLOCK_W-1:0] kern_last    = KLAST_RST;

    t_in_item  pending_requests [$];
    t_out_item due_results [$];

    int queued_in    = 0;
    int driven_in    = 0;
    int accepted_in  = 0;
    int results_seen = 0;
    int fault_count  = 0;
    bit no_idle      = 1'b0;

    // Expected output item for one request; updates the bench map
    function automatic t_out_item predict_alloc(t_in_item req);
        t_out_item         res;
        int                b;
        bit                found;
        longint unsigned   addr;
        res.result_address = '0;
        res.status         = ST_OK;
        addr               = req.block_address;
        found              = 1'b0;
        case (req.opcode)
            OP_INIT: begin
                for (b = 0; b < NUM_BLOCKS; b++)
                    frame_used[b] = (b >= int'(avail_blocks));
                frame_used[0] = 1'b1;
                for (b = int'(kern_first); b <= int'(kern_last) && b < NUM_BLOCKS; b++)
                    frame_used[b] = 1'b1;
            end
            OP_ALLOC_ANY: begin
                res.status = ST_NO_SPACE;
                for (b = 0; b < NUM_BLOCKS && !found; b++) begin
                    if (!frame_used[b]) begin
                        frame_used[b]      = 1'b1;
                        res.result_address = 32'(longint'(b) * BLOCK_BYTES);
                        res.status         = ST_OK;
                        found              = 1'b1;
                    end
                end
            end
            default: begin
                // allocate given and free share the address checks
                if (addr % BLOCK_BYTES != 0)
                    res.status = ST_UNALIGNED;
                else if (addr / BLOCK_BYTES >= NUM_BLOCKS)
                    res.status = ST_RANGE;
                else begin
                    b = int'(addr / BLOCK_BYTES);
                    if (req.opcode == OP_ALLOC_GIVEN) begin
                        if (frame_used[b])
                            res.status = ST_NO_SPACE;
                        else begin
                            frame_used[b]      = 1'b1;
                            res.result_address = 32'(longint'(b) * BLOCK_BYTES);
                        end
                    end else begin
                        if (!frame_used[b])
                            res.status = ST_DOUBLE_FREE;
                        else
                            frame_used[b] = 1'b0;
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic flag_fault(string what, logic [31:0] want, logic [31:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    task automatic queue_request(t_opcode op, logic [31:0] addr);
        t_in_item req;
        req.opcode        = op;
        req.block_address = addr;
        pending_requests.push_back(req);
        queued_in++;
    endtask

    // Returns once every queued item has been taken and answered
    task automatic wait_idle();
        do @(negedge i_clk);
        while (accepted_in != queued_in || due_results.size() != 0);
    endtask

    // One register write while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_AVAIL:  avail_blocks = data[AVAIL_W-1:0];
            CFG_KFIRST: kern_first   = data[KBLOCK_W-1:0];
            CFG_KLAST:  kern_last    = data[KBLOCK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Request driver: holds each item until taken, then may idle a while
    int in_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_in_valid <= 1'b0;
        else if (i_in_valid && accepted_in != driven_in)
            ;
        else if (in_gap != 0) begin
            in_gap--;
            i_in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
            i_in_item  <= pending_requests.pop_front();
            i_in_valid <= 1'b1;
            driven_in++;
            in_gap = no_idle ? 0 : $urandom_range(0, 6);
        end else
            i_in_valid <= 1'b0;
    end

    // Result receiver: random stalls per item plus two long hold-offs
    int rx_seen   = 0;
    int out_gap   = 0;
    int hold_idx  = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (results_seen != rx_seen) begin
            rx_seen = results_seen;
            out_gap = no_idle ? 0 : $urandom_range(0, 6);
        end
        if (hold_idx < 2 && results_seen >= (hold_idx == 0 ? 150 : 700)) begin
            hold_idx++;
            hold_left = 400;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (out_gap != 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else
            i_out_ready <= 1'b1;
    end

    // Monitor: predict on each taken request, check each taken result
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                due_results.push_back(predict_alloc(i_in_item));
                accepted_in++;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (due_results.size() == 0)
                    flag_fault("unexpected item", '0, o_out_item.result_address);
                else begin
                    want = due_results.pop_front();
                    if (o_out_item.result_address !== want.result_address)
                        flag_fault("result_address", want.result_address,
                                   o_out_item.result_address);
                    if (o_out_item.status !== want.status)
                        flag_fault("status", 32'(want.status), 32'(o_out_item.status));
                end
            end
        end
    end

    // Stimulus
    initial begin
        int                    phase;
        int                    window;
        int                    pick;
        int                    blk;
        logic [31:0]           addr;
        logic [CFG_DATA_W-1:0] avail;
        logic [CFG_DATA_W-1:0] kf;
        logic [CFG_DATA_W-1:0] kl;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Use before init, then the address error codes
        queue_request(OP_ALLOC_ANY,   32'h0000_0000);
        queue_request(OP_ALLOC_GIVEN, 32'h0000_1000);
        queue_request(OP_ALLOC_GIVEN, 32'h0000_1000);
        queue_request(OP_FREE,        32'h0000_1000);
        queue_request(OP_FREE,        32'h0000_1000);
        queue_request(OP_ALLOC_GIVEN, 32'h0000_0001);
        queue_request(OP_FREE,        32'hFFFF_FFFF);
        queue_request(OP_ALLOC_GIVEN, 32'h0100_0000);
        queue_request(OP_FREE,        32'hC000_0000);
        queue_request(OP_ALLOC_GIVEN, 32'h00FF_F000);
        // Init with reset settings; block 0 may be freed and handed out again
        queue_request(OP_INIT,        32'hFFFF_FFFF);
        queue_request(OP_ALLOC_ANY,   32'h0000_0000);
        queue_request(OP_FREE,        32'h0000_0000);
        queue_request(OP_ALLOC_ANY,   32'hFFFF_FFFF);
        queue_request(OP_ALLOC_GIVEN, 32'h0010_0000);
        wait_idle();

        // No memory and a reversed kernel range: map full, then one block back
        write_reg(CFG_AVAIL, 13'd0);
        write_reg(CFG_KFIRST, 13'd4095);
        write_reg(CFG_KLAST, 13'd0);
        write_reg(CFG_UNUSED, 13'h1FFF);
        queue_request(OP_INIT,        32'h0000_0000);
        queue_request(OP_ALLOC_ANY,   32'h0000_0000);
        queue_request(OP_FREE,        32'h00FF_F000);
        queue_request(OP_ALLOC_ANY,   32'h0000_0000);
        wait_idle();

        // Count beyond the map size, kernel over the whole map
        write_reg(CFG_AVAIL, 13'h1FFF);
        write_reg(CFG_KFIRST, 13'd0);
        write_reg(CFG_KLAST, 13'd4095);
        queue_request(OP_INIT,        32'h0000_0000);
        queue_request(OP_ALLOC_ANY,   32'h0000_0000);
        queue_request(OP_ALLOC_GIVEN, 32'h0000_0000);
        wait_idle();

        // Kernel on the top block only
        write_reg(CFG_AVAIL, 13'd4096);
        write_reg(CFG_KFIRST, 13'd4095);
        write_reg(CFG_KLAST, 13'd4095);
        queue_request(OP_INIT,        32'h0000_0000);
        queue_request(OP_ALLOC_GIVEN, 32'h00FF_F000);
        queue_request(OP_ALLOC_ANY,   32'h0000_0000);

        // Random phases, each starting from a freshly built map
        for (phase = 0; phase < 10; phase++) begin
            wait_idle();
            no_idle = (phase % 3 == 2);
            case ($urandom_range(0, 5))
                0:       avail = 13'd0;
                1:       avail = 13'(NUM_BLOCKS);
                2:       avail = 13'($urandom_range(1, 64));
                3:       avail = 13'($urandom_range(0, NUM_BLOCKS));
                4:       avail = 13'($urandom_range(NUM_BLOCKS + 1, 8191));
                default: avail = 13'($urandom_range(1, 400));
            endcase
            case ($urandom_range(0, 3))
                0:       kf = 13'd0;
                1:       kf = 13'd4095;
                2:       kf = 13'($urandom_range(0, 64));
                default: kf = 13'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       kl = 13'd0;
                1:       kl = 13'd4095;
                2:       kl = 13'($urandom_range(0, 300));
                default: kl = 13'($urandom);
            endcase
            write_reg(CFG_AVAIL, avail);
            write_reg(CFG_KFIRST, kf);
            write_reg(CFG_KLAST, kl);
            window = (phase % 4 == 3) ? NUM_BLOCKS - 1 : $urandom_range(8, 320);

            queue_request(OP_INIT, $urandom);
            repeat (99) begin
                pick = $urandom_range(0, 99);
                blk  = (pick % 10 == 0) ? $urandom_range(0, NUM_BLOCKS - 1)
                                        : $urandom_range(0, window);
                addr = 32'(longint'(blk) * BLOCK_BYTES);
                if (pick < 8)
                    queue_request(t_opcode'($urandom_range(0, 3)), $urandom);
                else if (pick < 11)
                    // aligned but past the map
                    queue_request((pick % 2) ? OP_FREE : OP_ALLOC_GIVEN,
                                  {8'($urandom_range(1, 255)), 12'($urandom), 12'h000});
                else if (pick < 14)
                    queue_request((pick % 2) ? OP_FREE : OP_ALLOC_GIVEN,
                                  addr | 32'($urandom_range(1, BLOCK_BYTES - 1)));
                else if (pick < 17)
                    queue_request(OP_INIT, $urandom);
                else if (pick < 50)
                    queue_request(OP_ALLOC_ANY, $urandom);
                else if (pick < 75)
                    queue_request(OP_ALLOC_GIVEN, addr);
                else
                    queue_request(OP_FREE, addr);
            end
        end

        // Drain, then allow for any stray item
        wait_idle();
        repeat (200) @(negedge i_clk);
        if (due_results.size() != 0)
            flag_fault("missing items", '0, 32'(due_results.size()));
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial begin
        #25_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/bpfa_pkg.sv
rtl/bpfa_ram.sv
rtl/bpfa_ctrl.sv
rtl/bpfa_dp.sv
rtl/bitmap_page_frame_allocator.sv
tb/bitmap_page_frame_allocator_tb.sv
